@@ rtl/apf_pkg.sv @@
// apf_pkg: types and constants shared by the articulation point finder and its checker.
// Depends on nothing.
package apf_pkg;

  localparam int VTX_W            = 7;
  localparam int CNT_W            = 7;
  localparam int DEF_MAX_VERTICES = 64;
  localparam logic [VTX_W-1:0] VC_RESET = 7'd64;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SEARCH   = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } apf_in_t;

  typedef struct packed {
    logic [VTX_W-1:0] cut_vertex;
    logic             found;
    logic             last;
  } apf_out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_PASS_INIT,
    S_SCAN,
    S_EXP,
    S_PUSH,
    S_POP,
    S_ADR,
    S_PASS_END,
    S_EMIT,
    S_FINAL
  } apf_state_t;

endpackage

@@ rtl/articulation_point_finder.sv @@
// Articulation point finder: adjacency bit matrix and DFS stack in synchronous RAMs.
// Depends on apf_pkg.
// Sequence: an edge transfer reads and writes the row of a, then that of b, then frees the block.
//   A search runs n+1 component counts (n = effective vertex count), each a scan of all n vertices
//   with a DFS expansion per visited vertex, bound by the single adjacency read port; each result
//   is loaded once the output is free, and results leave through one output register.
// Throughput: one item at a time; the next item is taken once the last result is loaded.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the adjacency RAM row by row,
//   during which no input transfer is taken (config writes still land).
module articulation_point_finder
  import apf_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  apf_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output apf_out_t         out_data,
  input  logic             cfg_we,
  input  logic [VTX_W-1:0] cfg_wdata
);

  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int NW  = (CW > VTX_W) ? CW : VTX_W;
  localparam logic [NW-1:0] NMAX     = NW'(MAX_VERTICES);
  localparam logic [CW-1:0] EMIT_CAP = CW'(MAX_VERTICES - 2);
  localparam logic [VW-1:0] LAST_ROW = VW'(MAX_VERTICES - 1);

  // storage
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [VW-1:0]           stk_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rdata_r;
  logic [VW-1:0]           stk_rdata_r;

  logic                    adj_we;
  logic [VW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [VW-1:0]           adj_raddr;
  logic                    stk_we;
  logic [VW-1:0]           stk_waddr;
  logic [VW-1:0]           stk_wdata;
  logic [VW-1:0]           stk_raddr;

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata_r <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  // control and datapath registers
  apf_state_t              state_r, state_nxt;
  logic [VTX_W-1:0]        vc_r, vc_nxt;
  logic [VW-1:0]           clr_r, clr_nxt;
  logic [VW-1:0]           edge_a_r, edge_a_nxt;
  logic [VW-1:0]           edge_b_r, edge_b_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] pend_r, pend_nxt;
  logic [CW-1:0]           top_r, top_nxt;
  logic [NW-1:0]           scan_r, scan_nxt;
  logic [NW-1:0]           skip_r, skip_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        base_r, base_nxt;
  logic                    base_pass_r, base_pass_nxt;
  logic [CW-1:0]           emitted_r, emitted_nxt;
  logic                    have_pend_r, have_pend_nxt;
  logic [VTX_W-1:0]        pend_v_r, pend_v_nxt;
  logic                    out_valid_r, out_valid_nxt;
  apf_out_t                out_data_r, out_data_nxt;

  // derived values
  logic [NW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] range_mask;
  logic [NW-1:0]           a_ext, b_ext;
  logic                    edge_ok;
  logic [MAX_VERTICES-1:0] pend_iso;
  logic [VW-1:0]           pend_idx;
  logic                    out_free;

  assign n_eff = (NW'(vc_r) > NMAX) ? NMAX : NW'(vc_r);

  always_comb begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      range_mask[v] = (NW'(v) < n_eff);
    end
  end

  assign a_ext   = NW'(in_data.vertex_a);
  assign b_ext   = NW'(in_data.vertex_b);
  assign edge_ok = (a_ext != '0) && (a_ext <= n_eff) && (b_ext != '0) && (b_ext <= n_eff);

  // lowest pending neighbour
  assign pend_iso = pend_r & (~pend_r + MAX_VERTICES'(1));
  always_comb begin
    pend_idx = '0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      if (pend_iso[v]) begin
        pend_idx = pend_idx | VW'(v);
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      vc_r        <= VC_RESET;
      clr_r       <= '0;
      top_r       <= '0;
      base_pass_r <= 1'b0;
      emitted_r   <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      visited_r   <= '0;
      base_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      clr_r       <= clr_nxt;
      top_r       <= top_nxt;
      base_pass_r <= base_pass_nxt;
      emitted_r   <= emitted_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
      visited_r   <= visited_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_a_r   <= edge_a_nxt;
    edge_b_r   <= edge_b_nxt;
    pend_r     <= pend_nxt;
    scan_r     <= scan_nxt;
    skip_r     <= skip_nxt;
    pend_v_r   <= pend_v_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    logic [CW-1:0] top_dec;
    logic [NW-1:0] skip_inc;
    logic          hit;

    top_dec  = top_r - CW'(1);
    skip_inc = skip_r + NW'(1);
    hit      = (cnt_r > base_r) && (emitted_r < EMIT_CAP);

    state_nxt     = state_r;
    vc_nxt        = cfg_we ? cfg_wdata : vc_r;
    clr_nxt       = clr_r;
    edge_a_nxt    = edge_a_r;
    edge_b_nxt    = edge_b_r;
    visited_nxt   = visited_r;
    pend_nxt      = pend_r;
    top_nxt       = top_r;
    scan_nxt      = scan_r;
    skip_nxt      = skip_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    base_pass_nxt = base_pass_r;
    emitted_nxt   = emitted_r;
    have_pend_nxt = have_pend_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    adj_we    = 1'b0;
    adj_waddr = edge_a_r;
    adj_wdata = '0;
    adj_raddr = edge_b_r;
    stk_we    = 1'b0;
    stk_waddr = top_r[VW-1:0];
    stk_wdata = pend_idx;
    stk_raddr = top_dec[VW-1:0];

    in_stall = (state_r != S_IDLE);

    unique case (state_r)
      S_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_r;
        clr_nxt   = clr_r + VW'(1);
        if (clr_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        adj_raddr = VW'(a_ext - NW'(1));
        if (in_valid) begin
          if (in_data.operation == OP_SEARCH) begin
            skip_nxt      = n_eff;
            base_pass_nxt = 1'b1;
            emitted_nxt   = '0;
            have_pend_nxt = 1'b0;
            state_nxt     = S_PASS_INIT;
          end else if (edge_ok) begin
            edge_a_nxt = VW'(a_ext - NW'(1));
            edge_b_nxt = VW'(b_ext - NW'(1));
            state_nxt  = S_ADD_WA;
          end
        end
      end

      S_ADD_WA: begin
        adj_we    = 1'b1;
        adj_waddr = edge_a_r;
        adj_wdata = adj_rdata_r | (MAX_VERTICES'(1) << edge_b_r);
        state_nxt = S_ADD_RB;
      end

      S_ADD_RB: begin
        adj_raddr = edge_b_r;
        state_nxt = S_ADD_WB;
      end

      S_ADD_WB: begin
        adj_we    = 1'b1;
        adj_waddr = edge_b_r;
        adj_wdata = adj_rdata_r | (MAX_VERTICES'(1) << edge_a_r);
        state_nxt = S_IDLE;
      end

      S_PASS_INIT: begin
        visited_nxt = '0;
        if (skip_r < n_eff) begin
          visited_nxt[skip_r[VW-1:0]] = 1'b1;
        end
        scan_nxt  = '0;
        cnt_nxt   = '0;
        top_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        adj_raddr = scan_r[VW-1:0];
        if (scan_r == n_eff) begin
          state_nxt = S_PASS_END;
        end else begin
          scan_nxt = scan_r + NW'(1);
          if (!visited_r[scan_r[VW-1:0]]) begin
            visited_nxt[scan_r[VW-1:0]] = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = S_EXP;
          end
        end
      end

      S_EXP: begin
        pend_nxt    = adj_rdata_r & ~visited_r & range_mask;
        visited_nxt = visited_r | (adj_rdata_r & range_mask);
        state_nxt   = S_PUSH;
      end

      S_PUSH: begin
        if (pend_r == '0) begin
          state_nxt = S_POP;
        end else begin
          stk_we   = 1'b1;
          top_nxt  = top_r + CW'(1);
          pend_nxt = pend_r & ~pend_iso;
        end
      end

      S_POP: begin
        if (top_r == '0) begin
          state_nxt = S_SCAN;
        end else begin
          top_nxt   = top_dec;
          state_nxt = S_ADR;
        end
      end

      S_ADR: begin
        adj_raddr = stk_rdata_r;
        state_nxt = S_EXP;
      end

      S_PASS_END: begin
        if (base_pass_r) begin
          base_nxt      = cnt_r;
          base_pass_nxt = 1'b0;
          skip_nxt      = '0;
          state_nxt     = (n_eff == '0) ? S_FINAL : S_PASS_INIT;
        end else if (hit && have_pend_r) begin
          state_nxt = S_EMIT;
        end else begin
          if (hit) begin
            have_pend_nxt = 1'b1;
            pend_v_nxt    = VTX_W'(skip_inc);
            emitted_nxt   = emitted_r + CW'(1);
          end
          skip_nxt  = skip_inc;
          state_nxt = (skip_inc == n_eff) ? S_FINAL : S_PASS_INIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cut_vertex = pend_v_r;
          out_data_nxt.found      = 1'b1;
          out_data_nxt.last       = 1'b0;
          pend_v_nxt              = VTX_W'(skip_inc);
          emitted_nxt             = emitted_r + CW'(1);
          skip_nxt                = skip_inc;
          state_nxt               = (skip_inc == n_eff) ? S_FINAL : S_PASS_INIT;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cut_vertex = have_pend_r ? pend_v_r : '0;
          out_data_nxt.found      = have_pend_r;
          out_data_nxt.last       = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/apf_checker.sv @@
// apf_checker: port-level assertions for articulation_point_finder, bound into that module.
// Depends on apf_pkg and articulation_point_finder.
module apf_checker
  import apf_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input apf_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input apf_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_found_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.cut_vertex != '0)
    else $error("found result without a vertex");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.last && out_data.cut_vertex == '0)
    else $error("empty result not final or carries a vertex");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_SEARCH |=> in_stall)
    else $error("search transfer did not occupy the block");

endmodule

bind articulation_point_finder apf_checker u_apf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
